// ----- rtl/core/sfp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sensor frame parser.
// No dependencies; imported by every module of the block.
package sfp_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = 4;

    localparam logic [7:0] HDR_BYTE  = 8'h40;
    localparam logic [7:0] TYPE_READ = 8'h03;
    localparam logic [7:0] TYPE_CAL  = 8'h06;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    localparam logic KIND_SLOT = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    typedef struct packed {
        logic kind;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic slot_pending;
    } t_cmdq_stat;

endpackage

// ----- rtl/core/sfp_front.sv -----
`timescale 1ns / 1ps
// Front end: frame parsing, payload buffer with clearing pass, command issue.
// Depends on sfp_pkg; feeds sfp_cmdq and serves buffer reads to sfp_back.
module sfp_front import sfp_pkg::*; #(
    parameter int BUF_DEPTH = 128,
    localparam int AW = $clog2(BUF_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [7:0]    i_rx_byte,
    output logic          o_cmd_push,
    output t_cmd          o_cmd,
    input  t_cmdq_stat    i_q,
    input  logic          i_slot_busy,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    localparam logic [9:0] DEPTH_W = 10'(BUF_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUF_DEPTH - 1);

    logic [7:0]    r_mem [BUF_DEPTH];
    logic [7:0]    r_rd_data;

    logic [1:0]    r_phase, n_phase;
    logic          r_mode, n_mode;
    logic [7:0]    r_len, n_len;
    logic [8:0]    r_idx, n_idx;
    logic          r_clr, n_clr;
    logic [AW-1:0] r_clr_addr, n_clr_addr;

    logic          w_accept;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [7:0]    w_wd;
    logic [8:0]    w_target;
    logic [8:0]    w_idx_inc;

    assign o_full = r_clr | i_q.full
                  | ((r_phase == PH_DATA) & (i_slot_busy | i_q.slot_pending));
    assign w_accept  = i_push & ~o_full;
    assign w_target  = r_mode ? {1'b0, r_len} : ({1'b0, r_len} + 9'd2);
    assign w_idx_inc = r_idx + 9'd1;
    assign o_rd_data = r_rd_data;

    always_comb begin
        n_phase    = r_phase;
        n_mode     = r_mode;
        n_len      = r_len;
        n_idx      = r_idx;
        n_clr      = r_clr;
        n_clr_addr = r_clr_addr;
        w_we       = 1'b0;
        w_wa       = r_idx[AW-1:0];
        w_wd       = i_rx_byte;
        o_cmd_push = 1'b0;
        o_cmd.kind = r_mode;
        if (r_clr) begin
            w_we       = 1'b1;
            w_wa       = r_clr_addr;
            w_wd       = 8'h00;
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                n_clr = 1'b0;
            end
        end else if (w_accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_rx_byte == HDR_BYTE) begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    if (i_rx_byte == TYPE_READ) begin
                        n_mode  = KIND_SLOT;
                        n_phase = PH_LEN;
                    end else if (i_rx_byte == TYPE_CAL) begin
                        n_mode  = KIND_ACK;
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_LEN: begin
                    n_len = i_rx_byte;
                    n_idx = 9'd0;
                    if (r_mode == KIND_ACK && i_rx_byte == 8'h00) begin
                        o_cmd_push = 1'b1;
                        o_cmd.kind = KIND_ACK;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if ({1'b0, r_idx} < DEPTH_W) begin
                        w_we = 1'b1;
                    end
                    n_idx = w_idx_inc;
                    if (w_idx_inc >= w_target) begin
                        o_cmd_push = 1'b1;
                        n_phase    = PH_IDLE;
                        n_idx      = 9'd0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_mode     <= 1'b0;
            r_len      <= 8'h00;
            r_idx      <= 9'd0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_phase    <= n_phase;
            r_mode     <= n_mode;
            r_len      <= n_len;
            r_idx      <= n_idx;
            r_clr      <= n_clr;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

`ifndef SYNTHESIS
    a_no_write_under_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !r_clr) |-> (!i_slot_busy && !i_q.slot_pending))
        else $error("payload write while slot walk pending");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> !i_q.full)
        else $error("command pushed into full queue");
    a_full_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> o_full)
        else $error("input open during clearing pass");
`endif

endmodule

// ----- rtl/core/sfp_cmdq.sv -----
`timescale 1ns / 1ps
// Two-entry command queue between front end and slot walker.
// Depends on sfp_pkg.
module sfp_cmdq import sfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_cmd,
    input  logic       i_pop,
    output t_cmd       o_cmd,
    output t_cmdq_stat o_stat
);

    logic [1:0] r_vld, n_vld;
    logic [1:0] r_kind;
    logic       r_wp;
    logic       r_rp;

    assign o_cmd.kind          = r_kind[r_rp];
    assign o_stat.full         = r_vld[r_wp];
    assign o_stat.empty        = ~r_vld[r_rp];
    assign o_stat.slot_pending = (r_vld[0] & (r_kind[0] == KIND_SLOT))
                               | (r_vld[1] & (r_kind[1] == KIND_SLOT));

    always_comb begin
        n_vld = r_vld;
        if (i_pop) begin
            n_vld[r_rp] = 1'b0;
        end
        if (i_push) begin
            n_vld[r_wp] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 2'b00;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push) begin
                r_wp <= ~r_wp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_kind[r_wp] <= i_cmd.kind;
        end
    end

endmodule

// ----- rtl/core/sfp_back.sv -----
`timescale 1ns / 1ps
// Back end: slot walker over the payload buffer and result register.
// Depends on sfp_pkg; reads the buffer held in sfp_front.
module sfp_back import sfp_pkg::*; #(
    parameter int BUF_DEPTH = 128,
    localparam int AW = $clog2(BUF_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_cmd_pop,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data,
    output logic          o_slot_busy,
    input  logic          i_pop,
    output logic          o_empty,
    output logic          o_kind,
    output logic [3:0]    o_slot,
    output logic          o_present,
    output logic [23:0]   o_value,
    output logic          o_last
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_ACK  = 3'd1;
    localparam logic [2:0] B_BM0  = 3'd2;
    localparam logic [2:0] B_BM1  = 3'd3;
    localparam logic [2:0] B_SLOT = 3'd4;
    localparam logic [2:0] B_V1   = 3'd5;
    localparam logic [2:0] B_V2   = 3'd6;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [15:0]       r_bm, n_bm;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [15:0]       r_val, n_val;

    logic              r_out_vld, n_out_vld;
    logic              r_kind, n_kind;
    logic [3:0]        r_oslot, n_oslot;
    logic              r_present, n_present;
    logic [23:0]       r_value, n_value;
    logic              r_last, n_last;

    logic              w_out_free;

    assign w_out_free  = ~r_out_vld | i_pop;
    assign o_rd_addr   = n_addr;
    assign o_slot_busy = (r_state != B_IDLE) && (r_state != B_ACK);
    assign o_empty     = ~r_out_vld;
    assign o_kind      = r_kind;
    assign o_slot      = r_oslot;
    assign o_present   = r_present;
    assign o_value     = r_value;
    assign o_last      = r_last;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_bm      = r_bm;
        n_slot    = r_slot;
        n_val     = r_val;
        n_out_vld = r_out_vld & ~i_pop;
        n_kind    = r_kind;
        n_oslot   = r_oslot;
        n_present = r_present;
        n_value   = r_value;
        n_last    = r_last;
        o_cmd_pop = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == KIND_ACK) begin
                        n_state = B_ACK;
                    end else begin
                        n_addr  = '0;
                        n_state = B_BM0;
                    end
                end
            end
            B_ACK: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_kind    = KIND_ACK;
                    n_oslot   = 4'd0;
                    n_present = 1'b0;
                    n_value   = 24'd0;
                    n_last    = 1'b1;
                    n_state   = B_IDLE;
                end
            end
            B_BM0: begin
                n_bm[15:8] = i_rd_data;
                n_addr     = AW'(1);
                n_state    = B_BM1;
            end
            B_BM1: begin
                n_bm[7:0] = i_rd_data;
                n_addr    = AW'(2);
                n_slot    = '0;
                n_state   = B_SLOT;
            end
            B_SLOT: begin
                if (r_bm[15]) begin
                    n_val[15:8] = i_rd_data;
                    n_addr      = r_addr + AW'(1);
                    n_state     = B_V1;
                end else if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_kind    = KIND_SLOT;
                    n_oslot   = r_slot;
                    n_present = 1'b0;
                    n_value   = 24'd0;
                    n_last    = (r_slot == LAST_SLOT);
                    n_bm      = {r_bm[14:0], 1'b0};
                    n_slot    = r_slot + SLOT_W'(1);
                    n_state   = (r_slot == LAST_SLOT) ? B_IDLE : B_SLOT;
                end
            end
            B_V1: begin
                n_val[7:0] = i_rd_data;
                n_addr     = r_addr + AW'(1);
                n_state    = B_V2;
            end
            B_V2: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_kind    = KIND_SLOT;
                    n_oslot   = r_slot;
                    n_present = 1'b1;
                    n_value   = {r_val, i_rd_data};
                    n_last    = (r_slot == LAST_SLOT);
                    n_bm      = {r_bm[14:0], 1'b0};
                    n_slot    = r_slot + SLOT_W'(1);
                    n_addr    = r_addr + AW'(1);
                    n_state   = (r_slot == LAST_SLOT) ? B_IDLE : B_SLOT;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_addr    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bm      <= n_bm;
        r_slot    <= n_slot;
        r_val     <= n_val;
        r_kind    <= n_kind;
        r_oslot   <= n_oslot;
        r_present <= n_present;
        r_value   <= n_value;
        r_last    <= n_last;
    end

endmodule

// ----- rtl/core/sensor_frame_parser.sv -----
`timescale 1ns / 1ps
// Sensor frame parser top level: one received byte per cycle on the input queue
// while full is low. A read reply starts a slot walk after its last byte: one result
// per cycle for an absent slot while results are taken; a present slot first reads
// its value bytes. A calibration reply yields its acknowledge after its last or
// length byte. Reset is synchronous; afterwards a clearing pass zeroes the buffer
// with full held high. Payload bytes stall while a slot walk is pending.
module sensor_frame_parser import sfp_pkg::*; #(
    parameter int BUF_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [3:0]  o_slot,
    output logic        o_present,
    output logic [23:0] o_value,
    output logic        o_last
);

    localparam int AW = $clog2(BUF_DEPTH);

    logic          w_cmd_push;
    t_cmd          w_cmd_in;
    t_cmd          w_cmd_out;
    t_cmdq_stat    w_q;
    logic          w_cmd_pop;
    logic          w_slot_busy;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_rd_data;

    sfp_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_rx_byte   (i_rx_byte),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_cmd_in),
        .i_q         (w_q),
        .i_slot_busy (w_slot_busy),
        .i_rd_addr   (w_rd_addr),
        .o_rd_data   (w_rd_data)
    );

    sfp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_cmd_out),
        .o_stat  (w_q)
    );

    sfp_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (~w_q.empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_slot_busy (w_slot_busy),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_kind      (o_kind),
        .o_slot      (o_slot),
        .o_present   (o_present),
        .o_value     (o_value),
        .o_last      (o_last)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sensor_frame_parser: byte stimulus, slot/ack prediction.
// Depends on rtl/core/sfp_pkg.sv and rtl/core/sensor_frame_parser.sv.
module tb_top;
    import sfp_pkg::*;

    localparam int BUF_DEPTH = 128;

    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic        present;
        logic [23:0] value;
        logic        last;
    } t_report;

    localparam t_report ACK_REPORT = '{kind: KIND_ACK, slot: 4'd0, present: 1'b0,
                                       value: 24'd0, last: 1'b1};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        full;
    logic        empty;
    logic        o_kind;
    logic [3:0]  o_slot;
    logic        o_present;
    logic [23:0] o_value;
    logic        o_last;

    // parser shadow state
    logic [1:0]  parse_phase;
    logic        cal_mode;
    logic [7:0]  frame_len;
    logic [8:0]  byte_cnt;
    logic [7:0]  frame_buf [BUF_DEPTH];

    t_report     pending_reports [$];
    int          items_accepted = 0;
    int          idle_skips = 0;
    int          mismatch_count = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          pop_holdoff = 0;

    sensor_frame_parser #(.BUF_DEPTH(BUF_DEPTH)) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_rx_byte (i_rx_byte),
        .empty     (empty),
        .pop       (pop),
        .o_kind    (o_kind),
        .o_slot    (o_slot),
        .o_present (o_present),
        .o_value   (o_value),
        .o_last    (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [7:0] stored(input int pos);
        return (pos < BUF_DEPTH) ? frame_buf[pos] : 8'h00;
    endfunction

    function automatic int frame_target();
        return cal_mode ? int'(frame_len) : int'(frame_len) + 2;
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        t_report    rep;
        logic [7:0] bitmap;
        int         n;
        case (parse_phase)
            PH_IDLE: begin
                if (b == HDR_BYTE) parse_phase = PH_TYPE;
                else idle_skips++;
            end
            PH_TYPE: begin
                if (b == TYPE_READ) begin
                    cal_mode = 1'b0;
                    parse_phase = PH_LEN;
                end else if (b == TYPE_CAL) begin
                    cal_mode = 1'b1;
                    parse_phase = PH_LEN;
                end else begin
                    parse_phase = PH_IDLE;
                end
            end
            PH_LEN: begin
                frame_len = b;
                byte_cnt = '0;
                if (frame_target() == 0) begin
                    parse_phase = PH_IDLE;
                    pending_reports.push_back(ACK_REPORT);
                end else begin
                    parse_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (byte_cnt < BUF_DEPTH) frame_buf[byte_cnt] = b;
                byte_cnt = byte_cnt + 9'd1;
                if (int'(byte_cnt) >= frame_target()) begin
                    parse_phase = PH_IDLE;
                    byte_cnt = '0;
                    if (cal_mode) begin
                        pending_reports.push_back(ACK_REPORT);
                    end else begin
                        n = 0;
                        for (int k = 0; k < SLOT_COUNT; k++) begin
                            bitmap = (k < 8) ? frame_buf[0] : frame_buf[1];
                            rep.kind = KIND_SLOT;
                            rep.slot = 4'(k);
                            rep.present = bitmap[7 - (k % 8)];
                            rep.value = '0;
                            if (rep.present) begin
                                rep.value = {stored(2 + n), stored(3 + n), stored(4 + n)};
                                n += 3;
                            end
                            rep.last = (k == SLOT_COUNT - 1);
                            pending_reports.push_back(rep);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push = 1'b1;
        i_rx_byte = b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_accepted++;
        predict_byte(b);
    endtask

    task automatic send_head(input logic [7:0] reply_type, input logic [7:0] len);
        send_byte(HDR_BYTE);
        send_byte(reply_type);
        send_byte(len);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        push = 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatch_count++;
    endtask

    always begin
        @(negedge i_clk);
        if (pop_holdoff > 0) begin
            pop = 1'b0;
            pop_holdoff--;
        end else begin
            pop = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_report want;
        if (i_rst_n && pop && !empty) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual kind %0d slot %0d %s",
                         $time, o_kind, o_slot, $sformatf("value 0x%0h", o_value));
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_kind !== want.kind) report_field("kind", want.kind, o_kind);
                if (o_slot !== want.slot) report_field("slot", want.slot, o_slot);
                if (o_present !== want.present)
                    report_field("present", want.present, o_present);
                if (o_value !== want.value) report_field("value", want.value, o_value);
                if (o_last !== want.last) report_field("last", want.last, o_last);
            end
        end
    end

    task automatic test_cleared_buffer();
        send_head(TYPE_READ, 8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
    endtask

    task automatic test_ignored_and_bad_type();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_head(TYPE_CAL, 8'h00);
    endtask

    task automatic test_cal_reply();
        send_head(TYPE_CAL, 8'h02);
        send_byte(8'hAA);
        send_byte(8'h55);
    endtask

    task automatic test_short_read();
        send_head(TYPE_READ, 8'h04);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_buffer_overrun();
        send_head(TYPE_READ, 8'h7F);
        send_byte(8'hFF);
        send_byte(8'hFF);
        repeat (127) send_byte(8'($urandom));
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        pop_holdoff = 300;
        repeat (2) begin
            send_head(TYPE_READ, 8'h03);
            send_byte(8'($urandom) | 8'h80);
            send_byte(8'($urandom));
            repeat (3) send_byte(8'($urandom));
        end
        wait_drain();
    endtask

    task automatic run_random(input int n, input int idle_pct, input int stall_pct);
        int          goal;
        int          pick;
        int          len;
        logic [15:0] bitmap;
        logic [7:0]  b;
        tx_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        goal = items_accepted - idle_skips + n;
        while (items_accepted - idle_skips < goal) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                bitmap = 16'($urandom);
                len = ($urandom_range(3) == 0) ? $urandom_range(20)
                                               : 3 * $countones(bitmap);
                send_head(TYPE_READ, 8'(len));
                send_byte(bitmap[15:8]);
                send_byte(bitmap[7:0]);
                repeat (len) send_byte(8'($urandom));
            end else if (pick < 80) begin
                len = $urandom_range(8);
                send_head(TYPE_CAL, 8'(len));
                repeat (len) send_byte(8'($urandom));
            end else if (pick < 90) begin
                b = 8'($urandom);
                if (b == TYPE_READ || b == TYPE_CAL) b = b ^ 8'h80;
                send_byte(HDR_BYTE);
                send_byte(b);
            end else begin
                b = 8'($urandom);
                if (b == HDR_BYTE) b = ~b;
                send_byte(b);
            end
        end
    endtask

    initial begin
        parse_phase = PH_IDLE;
        cal_mode = 1'b0;
        frame_len = '0;
        byte_cnt = '0;
        foreach (frame_buf[i]) frame_buf[i] = 8'h00;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_cleared_buffer();
        test_ignored_and_bad_type();
        test_cal_reply();
        test_short_read();
        test_buffer_overrun();
        test_backpressure();
        run_random(5, 0, 0);
        run_random(5, 84, 0);
        run_random(5, 0, 84);
        run_random(5, 17, 17);

        wait_drain();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/sfp_pkg.sv
rtl/core/sfp_front.sv
rtl/core/sfp_cmdq.sv
rtl/core/sfp_back.sv
rtl/core/sensor_frame_parser.sv
tb/tb_top.sv
